[rtl/barycentric_weights_core_assert.svh]
// ----------------------------------------------------------------------------
// Barycentric weights core: assertion macros
// Clocked checks that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef BARYCENTRIC_WEIGHTS_CORE_ASSERT_SVH
`define BARYCENTRIC_WEIGHTS_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Check that is off while reset is held.
`define BARY_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("barycentric_weights_core: check failed");
// Check that also holds during reset.
`define BARY_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("barycentric_weights_core: check failed");
`else
`define BARY_ASSERT(lbl, clk, rstn, prop)
`define BARY_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[rtl/bary_pkg.sv]
// ----------------------------------------------------------------------------
// Barycentric weights package
// Shared widths, defaults and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none
package bary_pkg;
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int WEIGHT_BITS    = 32;
  localparam int CFG_IDX_BITS   = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_V0X = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_V0Y = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_V1X = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_V1Y = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_V2X = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_V2Y = 3'd5;
endpackage
`default_nettype wire

[rtl/bary_if.sv]
// ----------------------------------------------------------------------------
// Barycentric weights channel interfaces
// Point request, weight result and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none
interface bary_in_if #(parameter int CW = bary_pkg::COORD_BITS_DEF);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  modport source (output valid, point_x, point_y, input ready);
  modport sink   (input valid, point_x, point_y, output ready);
endinterface

interface bary_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [bary_pkg::WEIGHT_BITS-1:0] weight0;
  logic signed [bary_pkg::WEIGHT_BITS-1:0] weight1;
  logic signed [bary_pkg::WEIGHT_BITS-1:0] weight2;
  logic                                   degenerate;
  logic                                   saturated;
  modport source (output valid, weight0, weight1, weight2, degenerate, saturated,
                  input ready);
  modport sink   (input valid, weight0, weight1, weight2, degenerate, saturated,
                  output ready);
endinterface

interface bary_cfg_if #(parameter int CW = bary_pkg::COORD_BITS_DEF);
  logic                              valid;
  logic                              ready;
  logic [bary_pkg::CFG_IDX_BITS-1:0] index;
  logic [CW-1:0]                     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/bary_div.sv]
// ----------------------------------------------------------------------------
// Barycentric weights divider
// Pipelined restoring divider, one quotient bit per stage, with rounding
// to nearest (ties away from zero) and saturation to the weight range.
// ----------------------------------------------------------------------------
`default_nettype none
module bary_div #(
  parameter int MW = 35,
  parameter int IW = 16,
  parameter int FB = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   en,
  input  wire logic [MW-1:0]                          num_mag,
  input  wire logic [MW-1:0]                          den_mag,
  input  wire logic                                   neg,
  output logic signed [bary_pkg::WEIGHT_BITS-1:0]     quo_r,
  output logic                                        sat_r
);
  localparam int RW = MW + IW;
  localparam int QW = IW + FB + 1;
  localparam int WB = bary_pkg::WEIGHT_BITS;
  localparam logic [QW-1:0] LIM_NEG = QW'(1) << (WB - 1);
  localparam logic [QW-1:0] LIM_POS = LIM_NEG - QW'(1);

  logic [RW-1:0] r_r   [QW+1];
  logic [MW-1:0] d_r   [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic          ovf_r [QW+1];
  logic          neg_r [QW+1];

  // entry stage: range check against the integer field
  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]   <= RW'(num_mag);
      d_r[0]   <= den_mag;
      q_r[0]   <= '0;
      ovf_r[0] <= RW'(num_mag) >= (RW'(den_mag) << IW);
      neg_r[0] <= neg;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_step
    logic [RW-1:0] rs;
    logic [RW-1:0] ds;
    logic          ge;
    always_comb begin
      if (j < IW) begin
        rs = r_r[j];
        ds = RW'(d_r[j]) << (IW - 1 - j);
      end else begin
        rs = r_r[j] << 1;
        ds = RW'(d_r[j]);
      end
      ge = rs >= ds;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        r_r[j+1]   <= ge ? rs - ds : rs;
        d_r[j+1]   <= d_r[j];
        q_r[j+1]   <= {q_r[j][QW-2:0], ge};
        ovf_r[j+1] <= ovf_r[j];
        neg_r[j+1] <= neg_r[j];
      end
    end
  end

  logic [QW-1:0]        mag;
  logic [QW-1:0]        lim;
  logic                 over;
  logic signed [WB-1:0] quo_nxt;
  always_comb begin
    mag  = ovf_r[QW] ? LIM_NEG + QW'(1)
                     : {1'b0, q_r[QW][QW-1:1]} + QW'(q_r[QW][0]);
    lim  = neg_r[QW] ? LIM_NEG : LIM_POS;
    over = mag > lim;
    if (over) begin
      mag = lim;
    end
    quo_nxt = neg_r[QW] ? WB'(-mag) : WB'(mag);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
      sat_r <= over;
    end
  end
endmodule
`default_nettype wire

[rtl/barycentric_weights_core.sv]
// ----------------------------------------------------------------------------
// Barycentric weights core
// Three barycentric weights of a 2D point against a configured triangle,
// as signed fixed point with FRAC_BITS fraction bits, rounded and saturated.
// ----------------------------------------------------------------------------
//  channel   direction  carries
//  cfg_chan  in         vertex register index and coordinate
//  in_chan   in         point_x, point_y
//  out_chan  out        weight0..2, degenerate, saturated
//
//  One request enters per cycle unless a held result stalls the pipeline.
//  The divider yields one quotient bit per stage, over 33 stages.
//  Reset (rst_n low at a clock edge) clears the vertices and all valid bits.
//  A held result freezes the whole pipeline; nothing is lost or repeated.
//  Configuration is always ready and takes effect for later requests.
`default_nettype none
`include "barycentric_weights_core_assert.svh"
module barycentric_weights_core #(
  parameter int COORD_BITS = bary_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = bary_pkg::FRAC_BITS_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  bary_cfg_if.sink   cfg_chan,
  bary_in_if.sink    in_chan,
  bary_out_if.source out_chan
);
  localparam int WB      = bary_pkg::WEIGHT_BITS;
  localparam int DW      = COORD_BITS + 1;   // edge vector
  localparam int PW      = 2 * DW;           // edge product
  localparam int AW      = PW + 1;           // doubled area
  localparam int IW      = WB - FRAC_BITS;
  localparam int QW      = IW + FRAC_BITS + 1;
  localparam int DIV_LAT = QW + 2;
  localparam int PRE     = 4;
  localparam int L       = PRE + DIV_LAT;

  // vertex registers
  logic signed [COORD_BITS-1:0] vx_r [3];
  logic signed [COORD_BITS-1:0] vy_r [3];

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        vx_r[k] <= '0;
        vy_r[k] <= '0;
      end
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        bary_pkg::REG_V0X: vx_r[0] <= cfg_chan.data;
        bary_pkg::REG_V0Y: vy_r[0] <= cfg_chan.data;
        bary_pkg::REG_V1X: vx_r[1] <= cfg_chan.data;
        bary_pkg::REG_V1Y: vy_r[1] <= cfg_chan.data;
        bary_pkg::REG_V2X: vx_r[2] <= cfg_chan.data;
        bary_pkg::REG_V2Y: vy_r[2] <= cfg_chan.data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // advance the whole pipeline unless the result stage is held
  logic         adv;
  logic [L-1:0] vld_r;
  assign adv           = !vld_r[L-1] || out_chan.ready;
  assign in_chan.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[L-2:0], in_chan.valid};
    end
  end

  // Four triangles: the full one, then vertex 0, 1, 2 replaced by the point.
  // Doubled area of (a,b,c) is (c-a).x*(b-a).y - (b-a).x*(c-a).y.
  logic signed [COORD_BITS-1:0] tx [4][3];
  logic signed [COORD_BITS-1:0] ty [4][3];
  always_comb begin
    for (int t = 0; t < 4; t++) begin
      for (int k = 0; k < 3; k++) begin
        if (t != 0 && k == t - 1) begin
          tx[t][k] = in_chan.point_x;
          ty[t][k] = in_chan.point_y;
        end else begin
          tx[t][k] = vx_r[k];
          ty[t][k] = vy_r[k];
        end
      end
    end
  end

  // stage 1: edge vectors
  logic signed [DW-1:0] e1x_r [4];
  logic signed [DW-1:0] e1y_r [4];
  logic signed [DW-1:0] e2x_r [4];
  logic signed [DW-1:0] e2y_r [4];
  // stage 2: cross products
  logic signed [PW-1:0] p1_r [4];
  logic signed [PW-1:0] p2_r [4];
  // stage 3: doubled areas
  logic signed [AW-1:0] area_r [4];
  // stage 4: divider operands
  logic [AW-1:0]        mag_r [4];
  logic                 sgn_r [4];
  logic                 deg_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int t = 0; t < 4; t++) begin
        e1x_r[t]  <= DW'(tx[t][1]) - DW'(tx[t][0]);
        e1y_r[t]  <= DW'(ty[t][1]) - DW'(ty[t][0]);
        e2x_r[t]  <= DW'(tx[t][2]) - DW'(tx[t][0]);
        e2y_r[t]  <= DW'(ty[t][2]) - DW'(ty[t][0]);
        p1_r[t]   <= e2x_r[t] * e1y_r[t];
        p2_r[t]   <= e1x_r[t] * e2y_r[t];
        area_r[t] <= AW'(p1_r[t]) - AW'(p2_r[t]);
        sgn_r[t]  <= area_r[t][AW-1];
        mag_r[t]  <= area_r[t][AW-1] ? AW'(-area_r[t]) : AW'(area_r[t]);
      end
      deg_r <= area_r[0] == '0;
    end
  end

  // carry the degenerate flag alongside the divider stages
  logic [DIV_LAT-1:0] degl_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      degl_r <= {degl_r[DIV_LAT-2:0], deg_r};
    end
  end

  logic signed [WB-1:0] quo [3];
  logic                 qsat [3];
  for (genvar i = 0; i < 3; i++) begin : g_div
    bary_div #(
      .MW (AW),
      .IW (IW),
      .FB (FRAC_BITS)
    ) u_div (
      .clk     (clk),
      .en      (adv),
      .num_mag (mag_r[i+1]),
      .den_mag (mag_r[0]),
      .neg     (sgn_r[i+1] ^ sgn_r[0]),
      .quo_r   (quo[i]),
      .sat_r   (qsat[i])
    );
  end

  // zero-area triangle: force weights to zero and drop the saturation flag
  logic deg_out;
  assign deg_out             = degl_r[DIV_LAT-1];
  assign out_chan.valid      = vld_r[L-1];
  assign out_chan.weight0    = deg_out ? '0 : quo[0];
  assign out_chan.weight1    = deg_out ? '0 : quo[1];
  assign out_chan.weight2    = deg_out ? '0 : quo[2];
  assign out_chan.degenerate = deg_out;
  assign out_chan.saturated  = !deg_out && (qsat[0] || qsat[1] || qsat[2]);

  `BARY_ASSERT(a_deg_zero, clk, rst_n, out_chan.valid && out_chan.degenerate |-> out_chan.weight0 == '0 && out_chan.weight1 == '0 && out_chan.weight2 == '0 && !out_chan.saturated)
  `BARY_ASSERT(a_sat_limit, clk, rst_n, out_chan.valid && qsat[0] && !deg_out |-> quo[0] == {1'b0, {(WB-1){1'b1}}} || quo[0] == {1'b1, {(WB-1){1'b0}}})
  `BARY_ASSERT(a_stall_hold, clk, rst_n, !adv |=> $stable(vld_r))
  `BARY_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> vld_r == '0)
endmodule
`default_nettype wire
